// ===== src/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types, stage counts and step functions for the steered wheel
// speed pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

   localparam int unsigned SQ_STAGES  = 50;
   localparam int unsigned DIV_STAGES = 67;
   localparam int unsigned NUM_STAGES = 5 + SQ_STAGES + 1 + DIV_STAGES + 1;

   localparam logic [1:0] REG_OFFSET_X = 2'd0;
   localparam logic [1:0] REG_OFFSET_Y = 2'd1;
   localparam logic [1:0] REG_HINGE_Y  = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;

   localparam logic [30:0] RADIUS_RESET = 31'd6554;
   localparam logic [32:0] LIMIT_POS    = 33'h0_7FFF_FFFF;
   localparam logic [32:0] LIMIT_NEG    = 33'h0_8000_0000;

   typedef struct packed {
      logic signed [50:0] num0;
      logic signed [49:0] cterm;
      logic               neg;
      logic               xzero;
   } side_type;

   typedef struct packed {
      logic [99:0] rad;
      logic [51:0] rem;
      logic [49:0] root;
      side_type    side;
   } sq_type;

   typedef struct packed {
      logic        neg;
      logic [66:0] dvd;
      logic [30:0] rem;
      logic [32:0] quo;
      logic        ovf;
   } dv_type;

   function automatic sq_type sq_step(sq_type cur);
      sq_type      nxt;
      logic [53:0] cand;
      logic [53:0] trial;
      nxt   = cur;
      cand  = {cur.rem, cur.rad[99:98]};
      trial = {2'b00, cur.root, 2'b01};
      if (cand >= trial) begin
         nxt.rem  = 52'(cand - trial);
         nxt.root = {cur.root[48:0], 1'b1};
      end else begin
         nxt.rem  = cand[51:0];
         nxt.root = {cur.root[48:0], 1'b0};
      end
      nxt.rad = {cur.rad[97:0], 2'b00};
      return nxt;
   endfunction

   function automatic dv_type dv_step(dv_type cur, logic [30:0] rad);
      dv_type      nxt;
      logic [31:0] cand;
      logic        qbit;
      nxt  = cur;
      cand = {cur.rem, cur.dvd[66]};
      qbit = (cand >= {1'b0, rad});
      if (qbit) begin
         nxt.rem = 31'(cand - {1'b0, rad});
      end else begin
         nxt.rem = cand[30:0];
      end
      nxt.ovf = cur.ovf | cur.quo[32];
      nxt.quo = {cur.quo[31:0], qbit};
      nxt.dvd = {cur.dvd[65:0], 1'b0};
      return nxt;
   endfunction

endpackage

`default_nettype wire

// ===== src/steered_wheel_speed.sv =====
// ----------------------------------------------------------------------------
// steered_wheel_speed
// Spin rate of one steered wheel from a body velocity command, Q16.16.
//
// req channel: one command per transfer (linear speed, turn rate, steer rate).
// rsp channel: one result per command, in order (spin rate, saturated flag).
// csr channel: register writes (offset x, offset y, hinge y, radius); always
// ready, to be used only while no command is in flight.
// Throughput is one command per cycle: four product stages, one square-root
// stage per root bit (50) and one division stage per dividend bit (67) set
// the depth. Every stage holds a valid bit and moves whenever the stage
// ahead of it is empty or moving, so bubbles close up and req_tready stays
// high while the output holds a result unless every stage is full.
// When the receiver stalls the result holds in the output register and the
// pipeline fills behind it; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register reset values (radius
// 6554, all offsets zero). A zero radius is used as one LSB.
// ----------------------------------------------------------------------------
`default_nettype none

module steered_wheel_speed
   import sws_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // linear_speed, turn_rate, steer_rate
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // wheel_spin_rate
   output logic             rsp_tuser,   // saturated
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int unsigned SQ0 = 5;
   localparam int unsigned NST = SQ0 + SQ_STAGES;
   localparam int unsigned DV0 = NST + 1;
   localparam int unsigned OST = DV0 + DIV_STAGES;

   logic signed [31:0] x_ff, y_ff, h_ff;
   logic [30:0]        radius_ff;
   logic [30:0]        rad;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] go;

   // stage 0
   logic signed [31:0] v0_ff, w0_ff, s0_ff;
   // stage 1
   logic signed [31:0] v1_ff;
   logic signed [49:0] pwy_ff, pwh_ff, pwx_ff, pws_ff;
   // stage 2
   logic [49:0]        ma_ff, mb_ff;
   side_type           sd2_ff;
   // stage 3
   logic [49:0]        aahh_ff, aahl_ff, aall_ff, bbhh_ff, bbhl_ff, bbll_ff;
   side_type           sd3_ff;
   // stage 4
   logic [99:0]        sum4_ff;
   side_type           sd4_ff;
   // root and divide stages
   sq_type             sq_ff [SQ_STAGES];
   dv_type             dv_ff [DIV_STAGES];
   logic               nneg_ff;
   logic [50:0]        nmag_ff;
   // output
   logic [31:0]        out_ff;
   logic               sat_ff;

   // next-value logic for the arithmetic stages
   logic signed [32:0] ws_in, hy_in;
   logic signed [63:0] pwy_full, pwh_full, pwx_full;
   logic signed [65:0] pws_full;
   logic signed [50:0] a_in;
   logic [50:0]        ma_in, mb_in;
   side_type           sd2_in;
   logic [99:0]        sum_in;
   sq_type             sq0_in;
   logic signed [51:0] num_in;
   logic [49:0]        root_fin;
   dv_type             dv0_in;
   logic [32:0]        lim_in, mag_in;
   logic               sat_in;
   logic [31:0]        out_in;

   assign rad = (radius_ff == 31'd0) ? 31'd1 : radius_ff;

   always_comb begin
      go[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         go[k] = !vld_ff[k] || go[k+1];
      end
   end

   assign req_tready = go[0];
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[OST];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = sat_ff;

   always_comb begin
      ws_in    = 33'(w0_ff) + 33'(s0_ff);
      hy_in    = 33'(h_ff) - 33'(y_ff);
      pwy_full = 64'(w0_ff) * 64'(y_ff);
      pwh_full = 64'(w0_ff) * 64'(h_ff);
      pwx_full = 64'(w0_ff) * 64'(x_ff);
      pws_full = 66'(ws_in) * 66'(hy_in);

      a_in  = 51'(v1_ff) - 51'(pwh_ff);
      ma_in = a_in[50] ? 51'(-a_in) : 51'(a_in);
      mb_in = pwx_ff[49] ? 51'(-51'(pwx_ff)) : 51'(51'(pwx_ff));
      sd2_in.num0  = 51'(v1_ff) - 51'(pwy_ff);
      sd2_in.cterm = pws_ff;
      sd2_in.neg   = v1_ff[31];
      sd2_in.xzero = (x_ff == 32'sd0);

      sum_in = ({aahh_ff, 50'd0} + {24'd0, aahl_ff, 26'd0} + {50'd0, aall_ff})
             + ({bbhh_ff, 50'd0} + {24'd0, bbhl_ff, 26'd0} + {50'd0, bbll_ff});

      sq0_in.rad  = sum4_ff;
      sq0_in.rem  = '0;
      sq0_in.root = '0;
      sq0_in.side = sd4_ff;

      root_fin = sq_ff[SQ_STAGES-1].root;
      if (sq_ff[SQ_STAGES-1].side.xzero) begin
         num_in = 52'(sq_ff[SQ_STAGES-1].side.num0);
      end else if (sq_ff[SQ_STAGES-1].side.neg) begin
         num_in = 52'(sq_ff[SQ_STAGES-1].side.cterm) - 52'(root_fin);
      end else begin
         num_in = 52'(sq_ff[SQ_STAGES-1].side.cterm) + 52'(root_fin);
      end

      dv0_in.neg = nneg_ff;
      dv0_in.dvd = {nmag_ff, 16'd0};
      dv0_in.rem = '0;
      dv0_in.quo = '0;
      dv0_in.ovf = 1'b0;

      lim_in = dv_ff[DIV_STAGES-1].neg ? LIMIT_NEG : LIMIT_POS;
      sat_in = dv_ff[DIV_STAGES-1].ovf || (dv_ff[DIV_STAGES-1].quo > lim_in);
      mag_in = sat_in ? lim_in : dv_ff[DIV_STAGES-1].quo;
      out_in = dv_ff[DIV_STAGES-1].neg ? 32'(-mag_in[31:0]) : mag_in[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff      <= '0;
         y_ff      <= '0;
         h_ff      <= '0;
         radius_ff <= RADIUS_RESET;
         vld_ff    <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_OFFSET_X: x_ff      <= csr_data;
               REG_OFFSET_Y: y_ff      <= csr_data;
               REG_HINGE_Y:  h_ff      <= csr_data;
               REG_RADIUS:   radius_ff <= csr_data[30:0];
               default:      ;
            endcase
         end
         if (go[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (go[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         v0_ff <= req_tdata[31:0];
         w0_ff <= req_tdata[63:32];
         s0_ff <= req_tdata[95:64];
      end
      if (go[1]) begin
         v1_ff  <= v0_ff;
         pwy_ff <= 50'(pwy_full >>> 16);
         pwh_ff <= 50'(pwh_full >>> 16);
         pwx_ff <= 50'(pwx_full >>> 16);
         pws_ff <= 50'(pws_full >>> 16);
      end
      if (go[2]) begin
         ma_ff  <= ma_in[49:0];
         mb_ff  <= mb_in[49:0];
         sd2_ff <= sd2_in;
      end
      if (go[3]) begin
         aahh_ff <= 50'(ma_ff[49:25]) * 50'(ma_ff[49:25]);
         aahl_ff <= 50'(ma_ff[49:25]) * 50'(ma_ff[24:0]);
         aall_ff <= 50'(ma_ff[24:0]) * 50'(ma_ff[24:0]);
         bbhh_ff <= 50'(mb_ff[49:25]) * 50'(mb_ff[49:25]);
         bbhl_ff <= 50'(mb_ff[49:25]) * 50'(mb_ff[24:0]);
         bbll_ff <= 50'(mb_ff[24:0]) * 50'(mb_ff[24:0]);
         sd3_ff  <= sd2_ff;
      end
      if (go[4]) begin
         sum4_ff <= sum_in;
         sd4_ff  <= sd3_ff;
      end
      if (go[SQ0]) begin
         sq_ff[0] <= sq_step(sq0_in);
      end
      for (int k = 1; k < SQ_STAGES; k++) begin
         if (go[SQ0+k]) begin
            sq_ff[k] <= sq_step(sq_ff[k-1]);
         end
      end
      if (go[NST]) begin
         nneg_ff <= num_in[51];
         nmag_ff <= num_in[51] ? 51'(-num_in) : num_in[50:0];
      end
      if (go[DV0]) begin
         dv_ff[0] <= dv_step(dv0_in, rad);
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         if (go[DV0+k]) begin
            dv_ff[k] <= dv_step(dv_ff[k-1], rad);
         end
      end
      if (go[OST]) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000))
      else $error("saturated result not at a limit");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input blocked without an output stall");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== test/sws_checker.sv =====
// ----------------------------------------------------------------------------
// sws_checker
// Watches the command, result and register channels of the steered wheel
// speed block, predicts each spin rate from the command and a shadow copy of
// the registers, and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_checker
   import sws_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output int               errors,
   output int               pending
);

   typedef struct packed {
      logic [31:0] rate;
      logic        sat;
   } spin_type;

   logic signed [31:0] offset_x, offset_y, hinge_y;
   logic [30:0]        radius;
   spin_type           spin_q[$];

   function automatic logic signed [79:0] fix_mul(logic signed [79:0] a,
                                                 logic signed [79:0] b);
      logic signed [159:0] p;
      p = 160'(a) * 160'(b);
      return 80'(p >>> 16);
   endfunction

   function automatic logic [63:0] floor_root(logic [127:0] sq);
      logic [63:0] r, c;
      r = 0;
      for (int i = 51; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if (128'(c) * 128'(c) <= sq) r = c;
      end
      return r;
   endfunction

   function automatic spin_type wheel_spin(logic signed [31:0] lin,
                                           logic signed [31:0] turn,
                                           logic signed [31:0] steer);
      logic signed [79:0] v, w, s, x, y, h, a, b, num;
      logic [63:0]        ma, mb, root;
      logic [79:0]        mag;
      logic [95:0]        quo, limit;
      logic [30:0]        rad;
      spin_type           res;
      v = 80'(lin); w = 80'(turn); s = 80'(steer);
      x = 80'(offset_x); y = 80'(offset_y); h = 80'(hinge_y);
      if (x == 0) begin
         num = v - fix_mul(w, y);
      end else begin
         a  = v - fix_mul(w, h);
         b  = fix_mul(w, x);
         ma = 64'(a < 0 ? -a : a);
         mb = 64'(b < 0 ? -b : b);
         root = floor_root(128'(ma) * 128'(ma) + 128'(mb) * 128'(mb));
         num = $signed({16'b0, root});
         if (v < 0) num = -num;
         num = num + fix_mul(w + s, h - y);
      end
      rad   = (radius == 0) ? 31'd1 : radius;
      mag   = 80'(num < 0 ? -num : num);
      quo   = {mag, 16'b0} / {65'b0, rad};
      limit = (num < 0) ? 96'h8000_0000 : 96'h7FFF_FFFF;
      res.sat = quo > limit;
      if (res.sat) quo = limit;
      res.rate = (num < 0) ? -quo[31:0] : quo[31:0];
      return res;
   endfunction

   assign pending = spin_q.size();

   always @(posedge clock) begin
      spin_type got, want;
      if (reset) begin
         offset_x <= 0;
         offset_y <= 0;
         hinge_y  <= 0;
         radius   <= RADIUS_RESET;
         errors   <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OFFSET_X: offset_x <= csr_data;
               REG_OFFSET_Y: offset_y <= csr_data;
               REG_HINGE_Y:  hinge_y  <= csr_data;
               REG_RADIUS:   radius   <= csr_data[30:0];
            endcase
         end
         if (req_tvalid && req_tready)
            spin_q.insert(spin_q.size(), wheel_spin(req_tdata[31:0], req_tdata[63:32],
                                                    req_tdata[95:64]));
         if (rsp_tvalid && rsp_tready) begin
            got.rate = rsp_tdata;
            got.sat  = rsp_tuser;
            if (spin_q.size() == 0) begin
               $display("%0t: unexpected result rate=%h sat=%b", $time,
                        got.rate, got.sat);
               errors <= errors + 1;
            end else begin
               want = spin_q.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch expected rate=%h sat=%b actual rate=%h sat=%b",
                           $time, want.rate, want.sat, got.rate, got.sat);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives commands and register settings into the steered wheel speed block
// under random idling on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import sws_pkg::*;

   localparam int WATCHDOG = 5000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0, req_tready;
   logic [95:0] req_tdata = 0;
   logic        rsp_tvalid, rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 0, csr_ready;
   logic [1:0]  csr_index = REG_OFFSET_X;
   logic [31:0] csr_data = 0;
   int          errors, pending;
   int          send_idle = 0, recv_idle = 0;
   int          quiet = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   steered_wheel_speed u_dut (.*);

   sws_checker u_check (.*);

   always @(negedge clock) rsp_tready <= $urandom_range(99) >= recv_idle;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet <= 0;
      else if (!reset) quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
         2: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return 32'($signed($urandom_range(1 << 23)) - (1 << 22));
         default: return ($urandom_range(1)) ? 32'h0 : 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic send_cmd(logic [31:0] lin, logic [31:0] turn, logic [31:0] steer);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1;
      req_tdata  <= {steer, turn, lin};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (130) @(negedge clock);
   endtask

   task automatic load_regs(logic [31:0] x, logic [31:0] y, logic [31:0] h,
                            logic [31:0] r);
      logic [31:0] vals[4];
      vals = '{x, y, h, r};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1;
         csr_index <= 2'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 0;
   endtask

   task automatic random_cmds(int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 3) begin
            send_idle = 54; recv_idle = 17;
         end else if (i == 2 * n / 3) begin
            send_idle = 0; recv_idle = 0;
         end
         send_cmd(pick_value(), pick_value(), pick_value());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_idle = 17; recv_idle = 54;

      // zero x offset path with reset geometry
      send_cmd(0, 0, 0);
      send_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_cmd(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000);
      drain();
      load_regs(0, 32'h0000_8000, 32'hFFFF_0000, 32'd65536);
      send_cmd(32'h0001_0000, 32'h0002_0000, 0);
      send_cmd(32'h8000_0000, 32'h7FFF_FFFF, 0);
      drain();
      // steered path, zero and negative linear speed
      load_regs(32'h0000_4000, 32'h0000_2000, 32'hFFFF_C000, 32'd6554);
      send_cmd(0, 32'h0001_0000, 32'h0000_8000);
      send_cmd(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000);
      send_cmd(32'h0003_0000, 0, 0);
      send_cmd(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      drain();
      // extremes of the geometry, smallest radius and zero radius
      load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
      send_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_cmd(0, 0, 0);
      drain();
      load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_cmd(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_cmd(32'h0000_0001, 32'hFFFF_FFFF, 0);
      drain();
      load_regs(32'h0000_0001, 0, 0, 0);
      send_cmd(32'h0000_0001, 0, 0);
      send_cmd(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
      drain();

      for (int p = 0; p < 6; p++) begin
         send_idle = 17; recv_idle = 54;
         case (p)
            0: load_regs(0, pick_value(), pick_value(), 32'd6554);
            1: load_regs(pick_value(), pick_value(), pick_value(),
                         $urandom_range(32'h7FFF_FFFF, 1));
            2: load_regs(pick_value(), pick_value(), pick_value(),
                         $urandom_range(32'h0004_0000, 1));
            3: load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
            4: load_regs(pick_value(), 0, pick_value(), 32'h7FFF_FFFF);
            default: load_regs(pick_value(), pick_value(), pick_value(),
                               $urandom_range(32'h0002_0000, 0));
         endcase
         random_cmds(240);
         drain();
      end

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
